// ===== rtl/palette_nearest_colour_search_macros.svh =====
// Assertion macros shared by the palette search RTL.
`ifndef PALETTE_NEAREST_COLOUR_SEARCH_MACROS_SVH
`define PALETTE_NEAREST_COLOUR_SEARCH_MACROS_SVH

// The antecedent holds in this cycle, so the consequent must hold in the same cycle.
`define PNCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("palette search assertion failed");

// The antecedent holds in this cycle, so the consequent must hold in the next cycle.
`define PNCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("palette search assertion failed");

`endif

// ===== rtl/pncs_pkg.sv =====
// Types and constants for the nearest palette colour search.
package pncs_pkg;

   // Field widths.
   localparam int COMP_W   = 8;
   localparam int COLOUR_W = 8;
   localparam int SQR_W    = 16;
   localparam int SQ_W     = 18;
   localparam int LIN_W    = 10;
   localparam int DARK_W   = 19;

   // Transaction kinds.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Tag that travels with each palette entry through the scan pipeline.
   typedef struct packed {
      logic                vld;
      logic                last;
      logic [COLOUR_W-1:0] idx;
   } tag_type;

   // Absolute differences and entry components.
   typedef struct packed {
      logic [COMP_W-1:0] dr;
      logic [COMP_W-1:0] dg;
      logic [COMP_W-1:0] db;
      logic [COMP_W-1:0] er;
      logic [COMP_W-1:0] eg;
      logic [COMP_W-1:0] eb;
   } diff_type;

   // Squares of the differences and of the entry components.
   typedef struct packed {
      logic [SQR_W-1:0] sdr;
      logic [SQR_W-1:0] sdg;
      logic [SQR_W-1:0] sdb;
      logic [SQR_W-1:0] ser;
      logic [SQR_W-1:0] seg;
      logic [SQR_W-1:0] seb;
      logic [LIN_W-1:0] lin;
   } square_type;

   // The three ordering measures of one entry.
   typedef struct packed {
      logic [SQ_W-1:0]   sq;
      logic [LIN_W-1:0]  lin;
      logic [DARK_W-1:0] dark;
   } metric_type;

endpackage

// ===== rtl/palette_nearest_colour_search.sv =====
// Nearest palette colour search: palette memory, scan pipeline and best-match tracking.
//
//   channel   ports                                     handshake
//   request   req_type req_entry_index req_red/green/blue  start & !busy
//   response  rsp_colour_index                          rsp_valid, one cycle
//
// A palette write is accepted while idle; busy stays low and a new transaction may follow at once.
// A query scans every entry through the single read port of the palette memory, which
// delivers one entry per cycle.
// Reset clears the entry valid bits at once; an entry never written reads as black.
// The response cannot be stalled; busy drops in the cycle the response is shown.
`include "palette_nearest_colour_search_macros.svh"

module palette_nearest_colour_search #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [pncs_pkg::COLOUR_W-1:0] req_entry_index,
   input  logic [pncs_pkg::COMP_W-1:0]   req_red,
   input  logic [pncs_pkg::COMP_W-1:0]   req_green,
   input  logic [pncs_pkg::COMP_W-1:0]   req_blue,
   output logic                          rsp_valid,
   output logic [pncs_pkg::COLOUR_W-1:0] rsp_colour_index
);

   localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
   localparam int ENTRY_W = 3 * pncs_pkg::COMP_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic accept, wr_accept, q_accept, wr_in_range;

   // Palette memory with one valid bit per entry.
   logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic rd_ok_ff;

   // Target colour of the running query.
   logic [pncs_pkg::COMP_W-1:0] tr_ff, tg_ff, tb_ff;

   // Pipeline stages.
   pncs_pkg::tag_type    t0_ff, t1_ff, t2_ff, t3_ff;
   pncs_pkg::diff_type   d1_ff, d1_in;
   pncs_pkg::square_type s2_ff, s2_in;
   pncs_pkg::metric_type m3_ff, m3_in;

   // Best candidate so far.
   pncs_pkg::metric_type best_ff;
   logic [pncs_pkg::COLOUR_W-1:0] best_idx_ff;
   logic have_ff;
   logic better;
   logic [pncs_pkg::COLOUR_W-1:0] final_idx;

   logic rsp_valid_ff;
   logic [pncs_pkg::COLOUR_W-1:0] rsp_idx_ff;

   logic [pncs_pkg::COMP_W-1:0] er, eg, eb;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign wr_accept   = accept && (req_type == pncs_pkg::REQ_WRITE);
   assign q_accept    = accept && (req_type == pncs_pkg::REQ_QUERY);
   assign wr_in_range = ({1'b0, req_entry_index} < 9'(PALETTE_ENTRIES));

   // Sequencer: issue one read per cycle, then wait for the pipeline to empty.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (q_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (t3_ff.vld && t3_ff.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // Palette write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_accept && wr_in_range) begin
         mem[req_entry_index[ADDR_W-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_accept && wr_in_range) begin
         valid_ff[req_entry_index[ADDR_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= valid_ff[addr_ff];
   end

   // Latch the target colour when a query is accepted.
   always_ff @(posedge clock) begin
      if (q_accept) begin
         tr_ff <= req_red;
         tg_ff <= req_green;
         tb_ff <= req_blue;
      end
   end

   // Stage 1: absolute component differences.
   assign er = rd_ok_ff ? rd_data_ff[23:16] : '0;
   assign eg = rd_ok_ff ? rd_data_ff[15:8]  : '0;
   assign eb = rd_ok_ff ? rd_data_ff[7:0]   : '0;

   always_comb begin
      d1_in.er = er;
      d1_in.eg = eg;
      d1_in.eb = eb;
      d1_in.dr = (tr_ff > er) ? (tr_ff - er) : (er - tr_ff);
      d1_in.dg = (tg_ff > eg) ? (tg_ff - eg) : (eg - tg_ff);
      d1_in.db = (tb_ff > eb) ? (tb_ff - eb) : (eb - tb_ff);
   end

   // Stage 2: squares and the sum of absolute differences.
   always_comb begin
      s2_in.sdr = 16'(d1_ff.dr) * 16'(d1_ff.dr);
      s2_in.sdg = 16'(d1_ff.dg) * 16'(d1_ff.dg);
      s2_in.sdb = 16'(d1_ff.db) * 16'(d1_ff.db);
      s2_in.ser = 16'(d1_ff.er) * 16'(d1_ff.er);
      s2_in.seg = 16'(d1_ff.eg) * 16'(d1_ff.eg);
      s2_in.seb = 16'(d1_ff.eb) * 16'(d1_ff.eb);
      s2_in.lin = pncs_pkg::LIN_W'(d1_ff.dr) + pncs_pkg::LIN_W'(d1_ff.dg)
                + pncs_pkg::LIN_W'(d1_ff.db);
   end

   // Stage 3: squared distance and darkness weight.
   always_comb begin
      m3_in.sq   = pncs_pkg::SQ_W'(s2_ff.sdr) + pncs_pkg::SQ_W'(s2_ff.sdg)
                 + pncs_pkg::SQ_W'(s2_ff.sdb);
      m3_in.lin  = s2_ff.lin;
      m3_in.dark = pncs_pkg::DARK_W'(s2_ff.seb)
                 + ((pncs_pkg::DARK_W'(s2_ff.seg) + pncs_pkg::DARK_W'(s2_ff.ser)) << 1);
   end

   // Pipeline registers and tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_ff.vld <= 1'b0;
         t1_ff.vld <= 1'b0;
         t2_ff.vld <= 1'b0;
         t3_ff.vld <= 1'b0;
      end else begin
         t0_ff.vld <= (state_ff == ST_SCAN);
         t1_ff.vld <= t0_ff.vld;
         t2_ff.vld <= t1_ff.vld;
         t3_ff.vld <= t2_ff.vld;
      end
      t0_ff.last <= (addr_ff == LAST_ADDR);
      t0_ff.idx  <= pncs_pkg::COLOUR_W'(addr_ff);
      t1_ff.last <= t0_ff.last;
      t1_ff.idx  <= t0_ff.idx;
      t2_ff.last <= t1_ff.last;
      t2_ff.idx  <= t1_ff.idx;
      t3_ff.last <= t2_ff.last;
      t3_ff.idx  <= t2_ff.idx;
      d1_ff <= d1_in;
      s2_ff <= s2_in;
      m3_ff <= m3_in;
   end

   // Stage 4: ordered comparison against the best entry so far.
   always_comb begin
      if (!have_ff) begin
         better = 1'b1;
      end else if (m3_ff.sq != best_ff.sq) begin
         better = (m3_ff.sq < best_ff.sq);
      end else if (m3_ff.lin != best_ff.lin) begin
         better = (m3_ff.lin < best_ff.lin);
      end else begin
         better = (m3_ff.dark < best_ff.dark);
      end
      final_idx = better ? t3_ff.idx : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (q_accept) begin
         have_ff <= 1'b0;
      end else if (t3_ff.vld) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (t3_ff.vld && better) begin
         best_ff     <= m3_ff;
         best_idx_ff <= t3_ff.idx;
      end
   end

   // Response strobe for one cycle after the last entry is compared.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= t3_ff.vld && t3_ff.last;
      end
      rsp_idx_ff <= final_idx;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_colour_index = rsp_idx_ff;

   // Checks on the sequencing.
   `PNCS_ASSERT_NEXT(a_query_goes_busy, q_accept, busy)
   `PNCS_ASSERT_NEXT(a_write_no_response, wr_accept, !rsp_valid && !busy)
   `PNCS_ASSERT_SAME(a_response_when_idle, rsp_valid, !busy)
   `PNCS_ASSERT_NEXT(a_last_gives_response, t3_ff.vld && t3_ff.last, rsp_valid)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest palette colour search block.
module tb_top;

   localparam int PALETTE_ENTRIES = 256;
   localparam int DIRECTED_COUNT  = 25;
   localparam int RANDOM_ITEMS    = 1675;
   localparam int DRAIN_CYCLES    = PALETTE_ENTRIES + 20;
   localparam int CYCLE_LIMIT     = 4_000_000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [pncs_pkg::COMP_W-1:0] red;
      logic [pncs_pkg::COMP_W-1:0] green;
      logic [pncs_pkg::COMP_W-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic                          kind;
      logic [pncs_pkg::COLOUR_W-1:0] entry;
      colour_type                    colour;
      logic                          has_answer;
      logic [pncs_pkg::COLOUR_W-1:0] answer;
   } directed_row_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_type;
   logic [pncs_pkg::COLOUR_W-1:0] req_entry_index;
   logic [pncs_pkg::COMP_W-1:0]   req_red;
   logic [pncs_pkg::COMP_W-1:0]   req_green;
   logic [pncs_pkg::COMP_W-1:0]   req_blue;
   logic                          rsp_valid;
   logic [pncs_pkg::COLOUR_W-1:0] rsp_colour_index;

   // Shadow of the palette and the indices still owed by the block.
   colour_type                    palette_shadow [PALETTE_ENTRIES];
   logic [pncs_pkg::COLOUR_W-1:0] expected_indices [$];
   directed_row_type              directed_rows [DIRECTED_COUNT];
   int                            mismatch_count;
   int                            items_sent;

   palette_nearest_colour_search #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_colour_index(rsp_colour_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length in case the block hangs.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // Scan the shadow palette: squared distance, then absolute distance, then darkness,
   // then the lowest index.
   function automatic logic [pncs_pkg::COLOUR_W-1:0] nearest_entry(input colour_type target);
      int                            dr, dg, db, sq, lin, dark;
      int                            best_sq, best_lin, best_dark;
      colour_type                    e;
      logic [pncs_pkg::COLOUR_W-1:0] best;
      best      = '0;
      best_sq   = 0;
      best_lin  = 0;
      best_dark = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         e  = palette_shadow[i];
         dr = int'(target.red) - int'(e.red);
         dg = int'(target.green) - int'(e.green);
         db = int'(target.blue) - int'(e.blue);
         if (dr < 0) dr = -dr;
         if (dg < 0) dg = -dg;
         if (db < 0) db = -db;
         sq   = dr * dr + dg * dg + db * db;
         lin  = dr + dg + db;
         dark = int'(e.blue) * int'(e.blue)
              + 2 * (int'(e.green) * int'(e.green) + int'(e.red) * int'(e.red));
         if (i == 0 || sq < best_sq ||
             (sq == best_sq && (lin < best_lin || (lin == best_lin && dark < best_dark)))) begin
            best      = pncs_pkg::COLOUR_W'(i);
            best_sq   = sq;
            best_lin  = lin;
            best_dark = dark;
         end
      end
      return best;
   endfunction

   // Move one component by up to span steps either way, clamped to its range.
   function automatic logic [pncs_pkg::COMP_W-1:0] nudge(input logic [pncs_pkg::COMP_W-1:0] v,
                                                        input int span);
      int t;
      t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return pncs_pkg::COMP_W'(t);
   endfunction

   function automatic colour_type jitter(input colour_type c, input int span);
      return '{nudge(c.red, span), nudge(c.green, span), nudge(c.blue, span)};
   endfunction

   function automatic logic [pncs_pkg::COMP_W-1:0] extreme_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   task automatic report(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Present one transaction, wait until it is taken, update the prediction and
   // then optionally leave the request line idle for a while.
   task automatic send_item(input logic kind, input logic [pncs_pkg::COLOUR_W-1:0] entry,
                            input colour_type colour, input logic has_answer,
                            input logic [pncs_pkg::COLOUR_W-1:0] answer, input int idle_pct);
      int gap;
      int pick;
      start           <= 1'b1;
      req_type        <= kind;
      req_entry_index <= entry;
      req_red         <= colour.red;
      req_green       <= colour.green;
      req_blue        <= colour.blue;
      do @(posedge clock); while (!(start && !busy));
      items_sent++;
      if (kind == pncs_pkg::REQ_WRITE) begin
         if (int'(entry) < PALETTE_ENTRIES)
            palette_shadow[entry] = colour;
      end else begin
         expected_indices.push_back(has_answer ? answer : nearest_entry(colour));
      end
      if (idle_pct > 0 && int'($urandom_range(0, 99)) < idle_pct) begin
         pick = int'($urandom_range(0, 9));
         gap  = (pick < 7) ? int'($urandom_range(1, 3)) :
                (pick < 9) ? int'($urandom_range(4, 20)) : int'($urandom_range(21, 300));
         // Noise on the fields while the request line is low.
         start           <= 1'b0;
         req_type        <= 1'($urandom);
         req_entry_index <= pncs_pkg::COLOUR_W'($urandom);
         req_red         <= pncs_pkg::COMP_W'($urandom);
         req_green       <= pncs_pkg::COMP_W'($urandom);
         req_blue        <= pncs_pkg::COMP_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // One round: load a handful of entries in some style, then query around them.
   task automatic run_round(input int idle_pct);
      int                            mode, n_writes, n_queries;
      logic [pncs_pkg::COLOUR_W-1:0] base, entry;
      colour_type                    center, c;
      mode      = int'($urandom_range(0, 3));
      n_writes  = int'($urandom_range(0, 16));
      n_queries = int'($urandom_range(1, 5));
      base      = pncs_pkg::COLOUR_W'($urandom);
      center    = colour_type'(24'($urandom));
      for (int k = 0; k < n_writes; k++) begin
         entry = $urandom_range(0, 1) ? base + pncs_pkg::COLOUR_W'($urandom_range(0, 15))
                                      : pncs_pkg::COLOUR_W'($urandom);
         case (mode)
            0: c = colour_type'(24'($urandom));
            1: c = jitter(center, 3);
            2: c = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
            default: c = '{extreme_level(), extreme_level(), extreme_level()};
         endcase
         send_item(pncs_pkg::REQ_WRITE, entry, c, 1'b0, '0, idle_pct);
      end
      for (int k = 0; k < n_queries; k++) begin
         case ($urandom_range(0, 4))
            0: c = colour_type'(24'($urandom));
            1: c = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
            2: c = jitter(palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)], 2);
            3: c = jitter(center, 4);
            default: c = '{extreme_level(), extreme_level(), extreme_level()};
         endcase
         send_item(pncs_pkg::REQ_QUERY, pncs_pkg::COLOUR_W'($urandom), c, 1'b0, '0, idle_pct);
      end
   endtask

   // Compare every response strobe with the oldest outstanding query.
   always @(posedge clock) begin
      logic [pncs_pkg::COLOUR_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_indices.size() == 0) begin
            report($sformatf("response %0d with no query outstanding", rsp_colour_index));
         end else begin
            want = expected_indices.pop_front();
            if (rsp_colour_index !== want)
               report($sformatf("colour_index expected %0d, got %0d", want, rsp_colour_index));
         end
      end
   end

   initial begin : stimulus
      int random_base;
      int phase;
      int idle_pct;
      start           <= 1'b0;
      reset           <= 1'b1;
      req_type        <= pncs_pkg::REQ_WRITE;
      req_entry_index <= '0;
      req_red         <= '0;
      req_green       <= '0;
      req_blue        <= '0;
      mismatch_count  = 0;
      items_sent      = 0;
      foreach (palette_shadow[i]) palette_shadow[i] = '0;

      // Directed transactions; answers typed in where they are obvious.
      directed_rows = '{
         // Cleared palette: everything is black, lowest index wins.
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd255, '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd0},
         // Exact matches, the first of two equal entries wins.
         '{pncs_pkg::REQ_WRITE, 8'd255, '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd90,  '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd255},
         '{pncs_pkg::REQ_WRITE, 8'd10,  '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd10},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd200, 8'd200, 8'd200}, 1'b1, 8'd10},
         '{pncs_pkg::REQ_WRITE, 8'd0,   '{8'd0,   8'd0,   8'd255}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd1},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd250}, 1'b1, 8'd0},
         // Pure red and pure green entries.
         '{pncs_pkg::REQ_WRITE, 8'd1,   '{8'd255, 8'd0,   8'd0},   1'b0, 8'd0},
         '{pncs_pkg::REQ_WRITE, 8'd2,   '{8'd0,   8'd255, 8'd0},   1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd254, 8'd1,   8'd0},   1'b1, 8'd1},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd1,   8'd254, 8'd0},   1'b1, 8'd2},
         // Equal squared distance, decided by the absolute distance.
         '{pncs_pkg::REQ_WRITE, 8'd20,  '{8'd100, 8'd100, 8'd105}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_WRITE, 8'd21,  '{8'd103, 8'd104, 8'd100}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd100, 8'd100, 8'd100}, 1'b0, 8'd0},
         // Equal in both distances, decided by darkness.
         '{pncs_pkg::REQ_WRITE, 8'd30,  '{8'd50,  8'd60,  8'd75},  1'b0, 8'd0},
         '{pncs_pkg::REQ_WRITE, 8'd31,  '{8'd55,  8'd60,  8'd70},  1'b0, 8'd0},
         '{pncs_pkg::REQ_WRITE, 8'd32,  '{8'd50,  8'd60,  8'd65},  1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd50,  8'd60,  8'd70},  1'b0, 8'd0},
         // Equal in every measure, decided by index.
         '{pncs_pkg::REQ_WRITE, 8'd40,  '{8'd170, 8'd85,  8'd170}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_WRITE, 8'd41,  '{8'd170, 8'd85,  8'd170}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd171, 8'd84,  8'd171}, 1'b0, 8'd0},
         '{pncs_pkg::REQ_QUERY, 8'd0,   '{8'd127, 8'd129, 8'd128}, 1'b0, 8'd0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].entry, directed_rows[i].colour,
                   directed_rows[i].has_answer, directed_rows[i].answer, 0);

      // Random part in three idling phases: none, heavy, moderate.
      random_base = items_sent;
      for (int i = 0; i < PALETTE_ENTRIES; i++)
         send_item(pncs_pkg::REQ_WRITE, pncs_pkg::COLOUR_W'(i), colour_type'(24'($urandom)),
                   1'b0, '0, 0);
      while (items_sent - random_base < RANDOM_ITEMS) begin
         phase = (items_sent - random_base) * 3 / RANDOM_ITEMS;
         case (phase)
            0:       idle_pct = 0;
            1:       idle_pct = 67;
            default: idle_pct = 27;
         endcase
         run_round(idle_pct);
      end
      start <= 1'b0;

      // Let outstanding queries finish, then watch for stray responses.
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
